### design/cpio_newc_archive_walker_assert.svh
// Assertion macros for the cpio newc walker checker.
// CW_ASSERT expects signals named clk and rst_n in the enclosing scope; CW_ASSERT_ALWAYS needs only clk.
`ifndef CPIO_NEWC_ARCHIVE_WALKER_ASSERT_SVH
`define CPIO_NEWC_ARCHIVE_WALKER_ASSERT_SVH

// Concurrent check, disabled while reset is held.
`define CW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check that also holds during reset.
`define CW_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/cwalk_pkg.sv
// Package for the cpio newc archive walker: types, codes, header constants.
// No dependencies; used by cwalk_step, the top level and the checker.
`timescale 1ns / 1ps

package cwalk_pkg;

    // Walk phases, one-hot
    typedef enum logic [6:0] {
        PH_HEADER   = 7'b0000001,
        PH_NAME     = 7'b0000010,
        PH_NAME_PAD = 7'b0000100,
        PH_DATA     = 7'b0001000,
        PH_DATA_PAD = 7'b0010000,
        PH_STOP_TRL = 7'b0100000,
        PH_STOP_MAG = 7'b1000000
    } phase_t;

    // Byte roles
    localparam logic [2:0] ROLE_HEADER   = 3'd0;
    localparam logic [2:0] ROLE_NAME     = 3'd1;
    localparam logic [2:0] ROLE_NAME_PAD = 3'd2;
    localparam logic [2:0] ROLE_DATA     = 3'd3;
    localparam logic [2:0] ROLE_DATA_PAD = 3'd4;
    localparam logic [2:0] ROLE_STOP     = 3'd5;

    // Stop codes
    localparam logic [1:0] STOP_NONE    = 2'd0;
    localparam logic [1:0] STOP_TRAILER = 2'd1;
    localparam logic [1:0] STOP_MAGIC   = 2'd2;

    // Header layout
    localparam logic [31:0] MAGIC_LEN   = 32'd6;
    localparam logic [31:0] FSIZE_POS   = 32'd54;
    localparam logic [31:0] FSIZE_LAST  = 32'd61;
    localparam logic [31:0] NSIZE_POS   = 32'd94;
    localparam logic [31:0] NSIZE_LAST  = 32'd101;
    localparam logic [31:0] HDR_LAST    = 32'd109;
    localparam logic [31:0] TRAILER_LEN = 32'd10;
    localparam logic [31:0] TRAILER_END = 32'd9;

    // Walker state carried from byte to byte
    typedef struct packed {
        phase_t      phase;
        logic [31:0] sec_cnt;
        logic [1:0]  ofs;        // entry offset, only the alignment bits matter
        logic [31:0] name_size;
        logic [31:0] file_size;
        logic [31:0] hex_acc;
        logic        trl_match;
        logic [15:0] entry_cnt;
    } walk_state_t;

    localparam walk_state_t WALK_RESET = '{
        phase:     PH_HEADER,
        sec_cnt:   32'd0,
        ofs:       2'd0,
        name_size: 32'd0,
        file_size: 32'd0,
        hex_acc:   32'd0,
        trl_match: 1'b1,
        entry_cnt: 16'd0
    };

    // One labeled byte
    typedef struct packed {
        logic [2:0]  role;
        logic [7:0]  data;
        logic [15:0] entry;
        logic [31:0] name_len;
        logic [31:0] file_len;
        logic        hdr_done;
        logic        ent_last;
        logic [1:0]  stop;
    } result_t;

    // Expected magic character at header position
    function automatic logic [7:0] magic_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h30;  // '0'
            3'd1:    c = 8'h37;  // '7'
            3'd2:    c = 8'h30;
            3'd3:    c = 8'h37;
            3'd4:    c = 8'h30;
            3'd5:    c = 8'h31;  // '1'
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "TRAILER!!!" character at name position
    function automatic logic [7:0] trailer_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h54;  // 'T'
            4'd1:    c = 8'h52;  // 'R'
            4'd2:    c = 8'h41;  // 'A'
            4'd3:    c = 8'h49;  // 'I'
            4'd4:    c = 8'h4C;  // 'L'
            4'd5:    c = 8'h45;  // 'E'
            4'd6:    c = 8'h52;  // 'R'
            4'd7:    c = 8'h21;  // '!'
            4'd8:    c = 8'h21;
            4'd9:    c = 8'h21;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // ASCII hex digit; anything else reads as zero
    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [3:0] d;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            d = c[3:0] + 4'd9;
        end else begin
            d = 4'd0;
        end
        return d;
    endfunction

endpackage

### design/cwalk_step.sv
// Next-state and labeling logic for one archive byte of the cpio walker.
// Depends on cwalk_pkg.
`timescale 1ns / 1ps

module cwalk_step (
    input  logic                  restart,
    input  logic [7:0]            archive_byte,
    input  cwalk_pkg::walk_state_t st_cur,
    output cwalk_pkg::walk_state_t st_next,
    output cwalk_pkg::result_t     res
);
    import cwalk_pkg::*;

    walk_state_t s;
    walk_state_t n;
    logic [31:0] idx;
    logic [31:0] idx_inc;
    logic [1:0]  ofs_inc;
    logic [31:0] acc;
    logic        trl_now;
    logic        go_npad;
    logic        go_data;
    logic        go_dpad;
    logic        go_fin;
    logic [2:0]  role;
    logic        hd;
    logic        el;
    logic [1:0]  code;

    always_comb
    begin
        s       = restart ? WALK_RESET : st_cur;
        n       = s;
        idx     = s.sec_cnt;
        idx_inc = s.sec_cnt + 32'd1;
        ofs_inc = s.ofs + 2'd1;
        acc     = {s.hex_acc[27:0], hex_digit(archive_byte)};
        trl_now = s.trl_match && (archive_byte == trailer_char(idx[3:0]));
        go_npad = 1'b0;
        go_data = 1'b0;
        go_dpad = 1'b0;
        go_fin  = 1'b0;
        role    = ROLE_STOP;
        hd      = 1'b0;
        el      = 1'b0;

        // Per-phase handling of this byte
        case (s.phase)
            PH_HEADER:
            begin
                role = ROLE_HEADER;
                if (idx < MAGIC_LEN && archive_byte != magic_char(idx[2:0])) begin
                    n.phase = PH_STOP_MAG;
                    role    = ROLE_STOP;
                end else begin
                    if ((idx >= FSIZE_POS && idx <= FSIZE_LAST) ||
                        (idx >= NSIZE_POS && idx <= NSIZE_LAST)) begin
                        n.hex_acc = acc;
                        if (idx == FSIZE_LAST) begin
                            n.file_size = acc;
                            n.hex_acc   = 32'd0;
                        end else if (idx == NSIZE_LAST) begin
                            n.name_size = acc;
                            n.hex_acc   = 32'd0;
                        end
                    end
                    n.sec_cnt = idx_inc;
                    n.ofs     = ofs_inc;
                    if (idx >= HDR_LAST) begin
                        hd          = 1'b1;
                        n.sec_cnt   = 32'd0;
                        n.trl_match = 1'b1;
                        if (n.name_size != 32'd0) begin
                            n.phase = PH_NAME;
                        end else begin
                            go_npad = 1'b1;
                        end
                    end
                end
            end
            PH_NAME:
            begin
                role = ROLE_NAME;
                if (idx < TRAILER_LEN) begin
                    n.trl_match = trl_now;
                end
                if (idx == TRAILER_END && trl_now) begin
                    n.phase = PH_STOP_TRL;
                    role    = ROLE_STOP;
                end else begin
                    n.sec_cnt = idx_inc;
                    n.ofs     = ofs_inc;
                    go_npad   = (idx_inc == s.name_size);
                end
            end
            PH_NAME_PAD:
            begin
                role    = ROLE_NAME_PAD;
                n.ofs   = ofs_inc;
                go_data = (ofs_inc == 2'd0);
            end
            PH_DATA:
            begin
                role      = ROLE_DATA;
                n.sec_cnt = idx_inc;
                n.ofs     = ofs_inc;
                go_dpad   = (idx_inc == s.file_size);
            end
            PH_DATA_PAD:
            begin
                role   = ROLE_DATA_PAD;
                n.ofs  = ofs_inc;
                go_fin = (ofs_inc == 2'd0);
            end
            default:
            begin
                role = ROLE_STOP;
            end
        endcase

        // Section transitions; empty sections fall straight through
        if (go_npad) begin
            if (n.ofs != 2'd0) begin
                n.phase = PH_NAME_PAD;
            end else begin
                go_data = 1'b1;
            end
        end
        if (go_data) begin
            n.sec_cnt = 32'd0;
            if (n.file_size != 32'd0) begin
                n.phase = PH_DATA;
            end else begin
                go_dpad = 1'b1;
            end
        end
        if (go_dpad) begin
            if (n.ofs != 2'd0) begin
                n.phase = PH_DATA_PAD;
            end else begin
                go_fin = 1'b1;
            end
        end
        if (go_fin) begin
            el        = 1'b1;
            n.phase   = PH_HEADER;
            n.sec_cnt = 32'd0;
            n.ofs     = 2'd0;
            if (n.entry_cnt != 16'hFFFF) begin
                n.entry_cnt = n.entry_cnt + 16'd1;
            end
        end

        // Stop code from the phase after this byte
        case (n.phase)
            PH_HEADER, PH_NAME, PH_NAME_PAD, PH_DATA, PH_DATA_PAD: code = STOP_NONE;
            PH_STOP_TRL: code = STOP_TRAILER;
            default:     code = STOP_MAGIC;
        endcase
    end

    assign st_next      = n;
    assign res.role     = role;
    assign res.data     = archive_byte;
    assign res.entry    = s.entry_cnt;
    assign res.name_len = n.name_size;
    assign res.file_len = n.file_size;
    assign res.hdr_done = hd;
    assign res.ent_last = el;
    assign res.stop     = code;

endmodule

### design/cpio_newc_archive_walker.sv
// Top level of the cpio newc archive walker: input register, walker state,
// result register and handshake. Depends on cwalk_pkg and cwalk_step.
`timescale 1ns / 1ps

// Usage
//   Input channel: archive_byte/restart with archive_valid, archive_stall.
//   A request moves when archive_valid is high and archive_stall is low.
//   Set restart on the first byte of each archive.
//   Output channel: one labeled result per input byte, on the result ports
//   with result_valid, result_stall; same handshake rule.
//   A result is registered: the step logic runs between the input register
//   and the result register.
//   Throughput: one byte per cycle while results are not stalled; the walker
//   state updates in the same cycle that a byte moves from the input register
//   to the result register.
//   When result_stall is held, the result register and the input register
//   both hold, and archive_stall rises only once both are full.
//   Reset (rst_n low, asynchronous) empties both registers and returns the
//   walker to the header phase of entry zero with both sizes cleared.

module cpio_newc_archive_walker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        archive_valid,
    output logic        archive_stall,
    input  logic [7:0]  archive_byte,
    input  logic        restart,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  byte_role,
    output logic [7:0]  passed_byte,
    output logic [15:0] entry_number,
    output logic [31:0] name_length,
    output logic [31:0] file_length,
    output logic        header_done,
    output logic        entry_last,
    output logic [1:0]  stop_code
);
    import cwalk_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_restart_reg;
    logic        out_valid_reg;
    result_t     res_reg;
    result_t     res_next;
    walk_state_t state_reg;
    walk_state_t state_next;
    logic        out_room;
    logic        advance;
    logic        in_take;

    // Flow control
    assign out_room      = !out_valid_reg || !result_stall;
    assign advance       = in_valid_reg && out_room;
    assign archive_stall = in_valid_reg && !out_room;
    assign in_take       = archive_valid && !archive_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take) begin
            in_byte_reg    <= archive_byte;
            in_restart_reg <= restart;
        end
    end

    // Step logic
    cwalk_step u_step (
        .restart      (in_restart_reg),
        .archive_byte (in_byte_reg),
        .st_cur       (state_reg),
        .st_next      (state_next),
        .res          (res_next)
    );

    // Walker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= WALK_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (out_room) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign byte_role    = res_reg.role;
    assign passed_byte  = res_reg.data;
    assign entry_number = res_reg.entry;
    assign name_length  = res_reg.name_len;
    assign file_length  = res_reg.file_len;
    assign header_done  = res_reg.hdr_done;
    assign entry_last   = res_reg.ent_last;
    assign stop_code    = res_reg.stop;

endmodule

### design/cwalk_checker.sv
// Port-level checker for the cpio newc archive walker, bound to the top.
// Depends on cwalk_pkg and cpio_newc_archive_walker_assert.svh.
`timescale 1ns / 1ps
`include "cpio_newc_archive_walker_assert.svh"

module cwalk_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        archive_stall,
    input logic        result_valid,
    input logic        result_stall,
    input logic [2:0]  byte_role,
    input logic [7:0]  passed_byte,
    input logic [15:0] entry_number,
    input logic [31:0] name_length,
    input logic [31:0] file_length,
    input logic        header_done,
    input logic        entry_last,
    input logic [1:0]  stop_code
);
    import cwalk_pkg::*;

    logic        res_held;
    logic [94:0] res_bus;
    logic        role_stop;
    logic        code_stop;
    logic        hdr_ok;

    // Result offered but held off; the whole result as one vector
    assign res_held  = result_valid && result_stall;
    assign res_bus   = {byte_role, passed_byte, entry_number, name_length, file_length,
                        header_done, entry_last, stop_code};
    assign role_stop = (byte_role == ROLE_STOP);
    assign code_stop = (stop_code != STOP_NONE);
    assign hdr_ok    = (byte_role == ROLE_HEADER) && !code_stop;

    // A stalled result holds
    `CW_ASSERT(a_res_hold, res_held |=> result_valid && $stable(res_bus), "held result changed")

    // Input side stalls only when the result side is full and stalled
    `CW_ASSERT_ALWAYS(a_stall_cause, archive_stall |-> res_held, "stall with no held result")

    // Stopped role always comes with a stop code, and only then
    `CW_ASSERT(a_stop_role, result_valid |-> role_stop == code_stop, "stop role vs stop code")

    // End of header is a header byte of a running walk
    `CW_ASSERT(a_hdr_done, result_valid && header_done |-> hdr_ok, "header_done off a header")

    // An entry never ends on a stopped byte
    `CW_ASSERT(a_ent_last, result_valid && entry_last |-> !code_stop, "entry_last while stopped")

endmodule

bind cpio_newc_archive_walker cwalk_checker u_cwalk_checker (.*);

### tb/tb_cpio_newc_archive_walker.sv
// Testbench for cpio_newc_archive_walker: streams generated newc archives, predicts
// each byte's label in a scoreboard and checks every result field.
// Depends on cwalk_pkg and the walker RTL only.
`timescale 1ns / 1ps

module tb_cpio_newc_archive_walker;

    import cwalk_pkg::*;

    localparam logic [47:0] MAGIC_TEXT   = "070701";
    localparam logic [79:0] TRAILER_TEXT = "TRAILER!!!";

    // Name content kinds for generated entries
    localparam int NAME_PLAIN   = 0;
    localparam int NAME_TRAILER = 1;
    localparam int NAME_NEAR    = 2;

    localparam int    GOOD_MAGIC = -1;
    localparam longint NO_CUT    = 64'd1 << 40;

    // Receiver stall modes
    localparam int STALL_NONE     = 0;
    localparam int STALL_LIGHT    = 1;
    localparam int STALL_HEAVY    = 2;
    localparam int STALL_PERIODIC = 3;

    localparam int ITEM_COUNT = 1750;

    typedef struct packed {
        logic [7:0] value;
        logic       restart_flag;
    } archive_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        archive_valid = 1'b0;
    logic        archive_stall;
    logic [7:0]  archive_byte = 8'h00;
    logic        restart = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [2:0]  byte_role;
    logic [7:0]  passed_byte;
    logic [15:0] entry_number;
    logic [31:0] name_length;
    logic [31:0] file_length;
    logic        header_done;
    logic        entry_last;
    logic [1:0]  stop_code;

    archive_req_t pending[$];
    result_t      labels_due[$];

    int  total_n = 0;
    int  taken_n = 0;
    int  checked_n = 0;
    int  mismatches = 0;
    bit  in_taken = 1'b0;
    bit  hold_off = 1'b0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  stall_mode = STALL_NONE;
    int  stall_tick = 0;

    // Predicted walker state
    phase_t      cur_phase;
    logic [31:0] sec_taken;
    logic [33:0] ent_ofs;
    logic [31:0] nsize_q;
    logic [31:0] fsize_q;
    logic [31:0] hex_acc;
    logic        trl_ok;
    logic [15:0] entries;

    cpio_newc_archive_walker uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .archive_valid (archive_valid),
        .archive_stall (archive_stall),
        .archive_byte  (archive_byte),
        .restart       (restart),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .byte_role     (byte_role),
        .passed_byte   (passed_byte),
        .entry_number  (entry_number),
        .name_length   (name_length),
        .file_length   (file_length),
        .header_done   (header_done),
        .entry_last    (entry_last),
        .stop_code     (stop_code)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ---------------------------------------------------------------- prediction

    function automatic void clear_walker();
        cur_phase = PH_HEADER;
        sec_taken = '0;
        ent_ofs   = '0;
        nsize_q   = '0;
        fsize_q   = '0;
        hex_acc   = '0;
        trl_ok    = 1'b1;
        entries   = '0;
    endfunction

    // ASCII hex value; any other character reads as zero
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= "0" && c <= "9")
            d = c - "0";
        else if (c >= "a" && c <= "f")
            d = c - "a" + 8'd10;
        else if (c >= "A" && c <= "F")
            d = c - "A" + 8'd10;
        return d[3:0];
    endfunction

    function automatic bit close_entry();
        if (entries != 16'hFFFF)
            entries = entries + 16'd1;
        cur_phase = PH_HEADER;
        sec_taken = '0;
        ent_ofs   = '0;
        return 1'b1;
    endfunction

    function automatic bit pad_after_data();
        if (ent_ofs[1:0] != 2'd0)
        begin
            cur_phase = PH_DATA_PAD;
            return 1'b0;
        end
        return close_entry();
    endfunction

    function automatic bit open_data();
        sec_taken = '0;
        if (fsize_q != 32'd0)
        begin
            cur_phase = PH_DATA;
            return 1'b0;
        end
        return pad_after_data();
    endfunction

    function automatic bit pad_after_name();
        if (ent_ofs[1:0] != 2'd0)
        begin
            cur_phase = PH_NAME_PAD;
            return 1'b0;
        end
        return open_data();
    endfunction

    // Label one archive byte and advance the predicted walker
    function automatic result_t label_byte(input logic [7:0] b, input logic rs);
        result_t     r;
        logic [31:0] idx;
        logic        last;
        if (rs)
            clear_walker();
        last       = 1'b0;
        idx        = sec_taken;
        r.role     = ROLE_STOP;
        r.data     = b;
        r.entry    = entries;
        r.hdr_done = 1'b0;
        case (cur_phase)
            PH_HEADER:
            begin
                r.role = ROLE_HEADER;
                if (idx < MAGIC_LEN && b != MAGIC_TEXT[8*(5-idx[2:0]) +: 8])
                begin
                    cur_phase = PH_STOP_MAG;
                    r.role    = ROLE_STOP;
                end
                else
                begin
                    // size fields shift in one hex digit per byte
                    if ((idx >= FSIZE_POS && idx <= FSIZE_LAST) ||
                        (idx >= NSIZE_POS && idx <= NSIZE_LAST))
                    begin
                        hex_acc = {hex_acc[27:0], nibble_of(b)};
                        if (idx == FSIZE_LAST)
                        begin
                            fsize_q = hex_acc;
                            hex_acc = '0;
                        end
                        else if (idx == NSIZE_LAST)
                        begin
                            nsize_q = hex_acc;
                            hex_acc = '0;
                        end
                    end
                    sec_taken = idx + 32'd1;
                    ent_ofs   = ent_ofs + 34'd1;
                    if (idx >= HDR_LAST)
                    begin
                        r.hdr_done = 1'b1;
                        sec_taken  = '0;
                        trl_ok     = 1'b1;
                        if (nsize_q != 32'd0)
                            cur_phase = PH_NAME;
                        else
                            last = pad_after_name();
                    end
                end
            end
            PH_NAME:
            begin
                r.role = ROLE_NAME;
                if (idx <= TRAILER_END && b != TRAILER_TEXT[8*(9-idx[3:0]) +: 8])
                    trl_ok = 1'b0;
                if (idx == TRAILER_END && trl_ok)
                begin
                    cur_phase = PH_STOP_TRL;
                    r.role    = ROLE_STOP;
                end
                else
                begin
                    sec_taken = idx + 32'd1;
                    ent_ofs   = ent_ofs + 34'd1;
                    if (sec_taken == nsize_q)
                        last = pad_after_name();
                end
            end
            PH_NAME_PAD:
            begin
                r.role  = ROLE_NAME_PAD;
                ent_ofs = ent_ofs + 34'd1;
                if (ent_ofs[1:0] == 2'd0)
                    last = open_data();
            end
            PH_DATA:
            begin
                r.role    = ROLE_DATA;
                sec_taken = idx + 32'd1;
                ent_ofs   = ent_ofs + 34'd1;
                if (sec_taken == fsize_q)
                    last = pad_after_data();
            end
            PH_DATA_PAD:
            begin
                r.role  = ROLE_DATA_PAD;
                ent_ofs = ent_ofs + 34'd1;
                if (ent_ofs[1:0] == 2'd0)
                    last = close_entry();
            end
            default:
                r.role = ROLE_STOP;
        endcase
        case (cur_phase)
            PH_STOP_TRL: r.stop = STOP_TRAILER;
            PH_STOP_MAG: r.stop = STOP_MAGIC;
            default:     r.stop = STOP_NONE;
        endcase
        r.name_len = nsize_q;
        r.file_len = fsize_q;
        r.ent_last = last;
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic void push_byte(input logic [7:0] b, input logic rs);
        archive_req_t q;
        q.value        = b;
        q.restart_flag = rs;
        pending.push_back(q);
    endfunction

    // Header digit: hex in random case, or a non-hex character when bad
    function automatic logic [7:0] digit_char(input logic [3:0] n, input bit bad);
        logic [7:0] c;
        if (bad)
        begin
            do
                c = 8'($urandom_range(0, 255));
            while (nibble_of(c) != 4'd0 || c == "0");
        end
        else if (n < 4'd10)
            c = "0" + n;
        else
            c = (($urandom_range(0, 1) == 0) ? "a" : "A") + n - 8'd10;
        return c;
    endfunction

    // One entry: header, name, pad, data, pad. bad_digits[7:0] spoil file size
    // digits, [15:8] name size digits (nibble index). body_max cuts the body short.
    task automatic add_entry(input logic [31:0] nsz, input logic [31:0] fsz,
                             input int name_kind, input int bad_pos, input bit first,
                             input longint body_max, input logic [15:0] bad_digits);
        logic [31:0] eff_n;
        logic [31:0] eff_f;
        logic [7:0]  c;
        longint      ofs;
        longint      npad;
        longint      dpad;
        longint      total;
        int          near_at;
        eff_n = nsz;
        eff_f = fsz;
        for (int i = 0; i < 8; i++)
        begin
            if (bad_digits[i])
                eff_f[4*i +: 4] = 4'd0;
            if (bad_digits[8+i])
                eff_n[4*i +: 4] = 4'd0;
        end
        for (int i = 0; i <= HDR_LAST; i++)
        begin
            if (i < MAGIC_LEN)
            begin
                c = MAGIC_TEXT[8*(5-i) +: 8];
                if (i == bad_pos)
                    c = c ^ 8'($urandom_range(1, 255));
            end
            else if (i >= FSIZE_POS && i <= FSIZE_LAST)
                c = digit_char(fsz[4*(FSIZE_LAST-i) +: 4], bad_digits[FSIZE_LAST-i]);
            else if (i >= NSIZE_POS && i <= NSIZE_LAST)
                c = digit_char(nsz[4*(NSIZE_LAST-i) +: 4], bad_digits[8+NSIZE_LAST-i]);
            else
                c = digit_char(4'($urandom_range(0, 15)), 1'b0);
            push_byte(c, first && i == 0);
            if (i == bad_pos)
            begin
                // walker has stopped; a few more bytes come out as stopped
                repeat ($urandom_range(1, 6))
                    push_byte(8'($urandom_range(0, 255)), 1'b0);
                return;
            end
        end
        ofs   = longint'(HDR_LAST) + 1 + longint'(eff_n);
        npad  = (4 - ofs % 4) % 4;
        ofs   = ofs + npad + longint'(eff_f);
        dpad  = (4 - ofs % 4) % 4;
        total = longint'(eff_n) + npad + longint'(eff_f) + dpad;
        if (total > body_max)
            total = body_max;
        near_at = $urandom_range(0, 9);
        for (longint k = 0; k < total; k++)
        begin
            if (k < longint'(eff_n))
            begin
                if (name_kind != NAME_PLAIN && k < 10)
                begin
                    c = TRAILER_TEXT[8*(9-k) +: 8];
                    if (name_kind == NAME_NEAR && k == near_at)
                        c = c ^ 8'($urandom_range(1, 255));
                end
                else if (k == longint'(eff_n) - 1)
                    c = 8'h00;
                else
                    c = 8'($urandom_range(32, 126));
            end
            else if (k >= longint'(eff_n) + npad && k < longint'(eff_n) + npad + longint'(eff_f))
                c = 8'($urandom_range(0, 255));
            else
                c = 8'h00;
            push_byte(c, 1'b0);
        end
    endtask

    task automatic build_stimulus();
        int          sel;
        int          kind;
        logic [31:0] nsz;
        logic [31:0] fsz;
        logic [15:0] bad;
        // bad magic on the first byte and on the last magic byte
        add_entry(0, 0, NAME_PLAIN, 0, 1'b1, NO_CUT, 16'h0000);
        add_entry(0, 0, NAME_PLAIN, 5, 1'b1, NO_CUT, 16'h0000);
        // empty name and data, one-byte name, non-hex digits, near trailers
        add_entry(0, 0, NAME_PLAIN, GOOD_MAGIC, 1'b1, NO_CUT, 16'h0000);
        add_entry(1, 0, NAME_PLAIN, GOOD_MAGIC, 1'b0, NO_CUT, 16'h0000);
        add_entry(32'h12, 32'h34, NAME_PLAIN, GOOD_MAGIC, 1'b0, NO_CUT, 16'h0201);
        add_entry(12, 5, NAME_NEAR, GOOD_MAGIC, 1'b0, NO_CUT, 16'h0000);
        add_entry(9, 4, NAME_TRAILER, GOOD_MAGIC, 1'b0, NO_CUT, 16'h0000);
        // trailer with exactly ten name bytes, then stopped bytes
        add_entry(10, 0, NAME_TRAILER, GOOD_MAGIC, 1'b0, NO_CUT, 16'h0000);
        repeat (4)
            push_byte(8'($urandom_range(0, 255)), 1'b0);
        // largest sizes; the stream is cut and the next archive restarts
        add_entry(5, 32'hFFFF_FFFF, NAME_PLAIN, GOOD_MAGIC, 1'b1, longint'(24), 16'h0000);
        add_entry(32'hFFFF_FFFF, 0, NAME_PLAIN, GOOD_MAGIC, 1'b1, longint'(24), 16'h0000);

        // random archives, mostly well formed
        while (pending.size() < total_n + ITEM_COUNT)
        begin
            sel = $urandom_range(0, 19);
            if (sel < 15)
            begin
                for (int e = 0; e < int'($urandom_range(1, 4)); e++)
                begin
                    kind = ($urandom_range(0, 7) == 0) ? NAME_NEAR : NAME_PLAIN;
                    if (kind == NAME_NEAR)
                        nsz = $urandom_range(10, 16);
                    else if ($urandom_range(0, 4) == 0)
                        nsz = $urandom_range(0, 3);
                    else
                        nsz = $urandom_range(4, 20);
                    sel = $urandom_range(0, 9);
                    if (sel < 3)
                        fsz = 0;
                    else if (sel == 9)
                        fsz = $urandom_range(49, 160);
                    else
                        fsz = $urandom_range(1, 48);
                    bad = ($urandom_range(0, 3) == 0) ? 16'($urandom & $urandom & $urandom) : 16'h0;
                    add_entry(nsz, fsz, kind, GOOD_MAGIC, e == 0, NO_CUT, bad);
                end
                add_entry(11, 0, NAME_TRAILER, GOOD_MAGIC, 1'b0, NO_CUT, 16'h0000);
                repeat ($urandom_range(0, 8))
                    push_byte(8'h00, 1'b0);
            end
            else if (sel < 17)
                add_entry($urandom_range(0, 20), $urandom_range(0, 40), NAME_PLAIN,
                          $urandom_range(0, 5), 1'b1, NO_CUT, 16'h0000);
            else if (sel < 19)
                add_entry($urandom_range(0, 20), $urandom_range(0, 40), NAME_PLAIN,
                          GOOD_MAGIC, 1'b1, longint'($urandom_range(0, 30)), 16'h0000);
            else
            begin
                // noise with stray restarts
                repeat ($urandom_range(3, 20))
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            end
        end
    endtask

    // ---------------------------------------------------------------- driver

    // Sender: bursts of requests with gaps; a held request keeps its payload
    always @(negedge clk)
    begin : send_requests
        archive_req_t nxt;
        logic         v;
        if (rst_n)
        begin
            v = archive_valid && !in_taken;
            if (!v)
            begin
                if (gap_left > 0 && !hold_off)
                    gap_left = gap_left - 1;
                else if (pending.size() > 0)
                begin
                    nxt = pending.pop_front();
                    archive_byte <= nxt.value;
                    restart      <= nxt.restart_flag;
                    v = 1'b1;
                    if (burst_left > 0)
                        burst_left = burst_left - 1;
                    else
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                                 : $urandom_range(0, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            archive_valid <= v;
        end
    end

    // Receiver: stall pattern switches among none, light, heavy and periodic modes
    always @(negedge clk)
    begin : stall_results
        logic s;
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
            stall_left = $urandom_range(20, 150);
        end
        stall_left = stall_left - 1;
        stall_tick = stall_tick + 1;
        case (stall_mode)
            STALL_NONE:  s = 1'b0;
            STALL_LIGHT: s = ($urandom_range(0, 4) == 0);
            STALL_HEAVY: s = ($urandom_range(0, 2) != 0);
            default:     s = (stall_tick % 3 == 0);
        endcase
        result_stall <= hold_off || s;
    end

    // Long receiver hold-off while the sender keeps offering, to back up the pipe
    initial
    begin
        wait (taken_n >= 500);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (80) @(posedge clk);
        hold_off = 1'b0;
    end

    // ---------------------------------------------------------------- monitor

    task automatic report_mismatch(input string what, input logic [31:0] seen,
                                   input logic [31:0] wanted);
        if (mismatches < 40)
            $display("%0t ns: %s: got %0h, want %0h (result %0d)",
                     $time, what, seen, wanted, checked_n);
        mismatches = mismatches + 1;
    endtask

    always @(posedge clk)
    begin : watch_ports
        result_t got;
        result_t want;
        in_taken = rst_n && archive_valid && !archive_stall;
        if (rst_n && result_valid && !result_stall)
        begin
            got = {byte_role, passed_byte, entry_number, name_length, file_length,
                   header_done, entry_last, stop_code};
            if (labels_due.size() == 0)
                report_mismatch("result with nothing expected", 32'(passed_byte), 32'd0);
            else
            begin
                want = labels_due.pop_front();
                if (got.role !== want.role)
                    report_mismatch("byte_role", 32'(got.role), 32'(want.role));
                if (got.data !== want.data)
                    report_mismatch("passed_byte", 32'(got.data), 32'(want.data));
                if (got.entry !== want.entry)
                    report_mismatch("entry_number", 32'(got.entry), 32'(want.entry));
                if (got.name_len !== want.name_len)
                    report_mismatch("name_length", got.name_len, want.name_len);
                if (got.file_len !== want.file_len)
                    report_mismatch("file_length", got.file_len, want.file_len);
                if (got.hdr_done !== want.hdr_done)
                    report_mismatch("header_done", 32'(got.hdr_done), 32'(want.hdr_done));
                if (got.ent_last !== want.ent_last)
                    report_mismatch("entry_last", 32'(got.ent_last), 32'(want.ent_last));
                if (got.stop !== want.stop)
                    report_mismatch("stop_code", 32'(got.stop), 32'(want.stop));
                checked_n = checked_n + 1;
            end
        end
        if (in_taken)
        begin
            labels_due.push_back(label_byte(archive_byte, restart));
            taken_n = taken_n + 1;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        clear_walker();
        total_n = 0;
        build_stimulus();
        total_n = pending.size();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait (taken_n == total_n);
        wait (checked_n == taken_n);
        // two-stage pipe: give stray results time to show up
        repeat (10) @(posedge clk);
        if (mismatches == 0 && labels_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/cwalk_pkg.sv
design/cwalk_step.sv
design/cpio_newc_archive_walker.sv
design/cwalk_checker.sv
tb/tb_cpio_newc_archive_walker.sv
